/* rtl/assert_macros.svh */
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define GSSA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`define GSSA_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define GSSA_ASSERT(label, clk, rst, prop)

`define GSSA_NEVER(label, clk, rst, cond)

`endif

`endif

/* rtl/gssa_pkg.sv */
`timescale 1ns / 1ps

package gssa_pkg;

  localparam int MAX_SLOTS    = 1024;
  localparam int PAGE_BYTES   = 4096;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  // slot stride is two pages: stack page plus guard page
  localparam int STRIDE_SHIFT = PAGE_SHIFT + 1;
  localparam int SLOT_W       = $clog2(MAX_SLOTS);
  localparam int COUNT_W      = SLOT_W + 1;
  localparam int ADDR_W       = 64;
  localparam int START_W      = 10;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 64;

  localparam logic [8:0]        GUARD_PML4_INDEX = 9'h1FE;
  localparam logic [ADDR_W-1:0] BASE_RESET       = {16'hFFFF, GUARD_PML4_INDEX, 39'b0};

  localparam logic [CFG_IDX_W-1:0] CFG_AREA_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SLOT = 1'b1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_MAP_FAIL  = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] stack_top;
    logic              map_ok;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] alloc_top;
  } rsp_t;

endpackage

/* rtl/gssa_slot_ram.sv */
`timescale 1ns / 1ps

module gssa_slot_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* rtl/guarded_stack_slot_allocator_unit.sv */
`timescale 1ns / 1ps
// Results: an accepted item moves to the WORK state, and its result is registered
// from there once the output register is free; it holds while rsp_stall is high.
// Flow: req_stall is high while an item is in WORK, which covers the read of the
// single-port free-slot memory. The next item is taken while a result waits.
// Reset (rst, synchronous): free count and last slot cleared, area base back to
// its default; the free-slot memory is not cleared and needs no clearing pass.

module guarded_stack_slot_allocator_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  gssa_pkg::req_t                     req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output gssa_pkg::rsp_t                     rsp,
  input  logic                               cfg_we,
  input  logic [gssa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gssa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import gssa_pkg::*;

  `include "assert_macros.svh"

  localparam int LOW_W = STRIDE_SHIFT + SLOT_W;

  typedef enum logic {
    IDLE,
    WORK
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   base_plus_page;
  logic [SLOT_W-1:0]   last_slot;
  logic [COUNT_W-1:0]  free_count;
  logic                pend_pop;
  logic                pend_ok;
  logic [1:0]          pend_status;
  logic [SLOT_W-1:0]   bump_slot;

  logic                accept;
  logic                is_alloc;
  logic                store_empty;
  logic                store_full;
  logic [SLOT_W:0]     next_slot;
  logic [LOW_W-1:0]    free_off;
  logic [SLOT_W-1:0]   free_idx;
  logic                ram_en;
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_addr;
  logic [SLOT_W-1:0]   ram_rdata;
  logic [SLOT_W-1:0]   res_slot;
  logic [ADDR_W-1:0]   res_top;
  logic                out_free;
  logic [START_W-1:0]  start_val;

  assign req_stall   = (state == WORK);
  assign accept      = req_valid && !req_stall;
  assign is_alloc    = (req.req_type == REQ_ALLOC);
  assign store_empty = (free_count == '0);
  assign store_full  = (free_count == COUNT_W'(MAX_SLOTS));
  assign next_slot   = {1'b0, last_slot} + (SLOT_W + 1)'(1);

  // slot index of a freed top, taken modulo the area size from the low bits
  assign free_off = req.stack_top[LOW_W-1:0] - base_plus_page[LOW_W-1:0];
  assign free_idx = free_off[LOW_W-1:STRIDE_SHIFT];

  assign ram_en   = accept && (is_alloc ? !store_empty : !store_full);
  assign ram_we   = !is_alloc;
  assign ram_addr = is_alloc ? SLOT_W'(free_count - COUNT_W'(1)) : free_count[SLOT_W-1:0];

  gssa_slot_ram #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (SLOT_W)
  ) u_slot_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (free_idx),
    .rdata (ram_rdata)
  );

  assign res_slot  = pend_pop ? ram_rdata : bump_slot;
  assign res_top   = pend_ok ? base_plus_page + (ADDR_W'(res_slot) << STRIDE_SHIFT) : '0;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign start_val = cfg_data[START_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      rsp_valid      <= 1'b0;
      base_plus_page <= BASE_RESET + ADDR_W'(PAGE_BYTES);
      last_slot      <= '0;
      free_count     <= '0;
    end else begin
      // drop the taken item unless a new one is loaded below
      if (rsp_valid && !rsp_stall && state != WORK) begin
        rsp_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_AREA_BASE: begin
            base_plus_page <= cfg_data + ADDR_W'(PAGE_BYTES);
          end
          CFG_START_SLOT: begin
            if (32'(start_val) >= MAX_SLOTS) begin
              last_slot <= SLOT_W'(MAX_SLOTS - 1);
            end else begin
              last_slot <= SLOT_W'(start_val);
            end
          end
          default: ;
        endcase
      end

      unique case (state)
        IDLE: begin
          if (accept) begin
            state       <= WORK;
            pend_pop    <= 1'b0;
            pend_ok     <= 1'b0;
            pend_status <= ST_OK;
            bump_slot   <= next_slot[SLOT_W-1:0];
            if (is_alloc) begin
              if (!store_empty) begin
                // pop: the memory read lands next cycle
                free_count <= free_count - COUNT_W'(1);
                pend_pop   <= 1'b1;
                pend_ok    <= 1'b1;
              end else if (32'(next_slot) >= MAX_SLOTS) begin
                pend_status <= ST_EXHAUSTED;
              end else if (!req.map_ok) begin
                pend_status <= ST_MAP_FAIL;
              end else begin
                last_slot <= next_slot[SLOT_W-1:0];
                pend_ok   <= 1'b1;
              end
            end else if (!store_full) begin
              free_count <= free_count + COUNT_W'(1);
            end
          end
        end
        WORK: begin
          // hold until the output register can take the item
          if (out_free) begin
            state         <= IDLE;
            rsp_valid     <= 1'b1;
            rsp.status    <= pend_status;
            rsp.alloc_top <= res_top;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `GSSA_ASSERT(a_accept_then_busy, clk, rst, accept |=> req_stall)
  `GSSA_NEVER(a_count_range, clk, rst, free_count > COUNT_W'(MAX_SLOTS))
  `GSSA_ASSERT(a_pop_decrements, clk, rst,
    (accept && is_alloc && !store_empty) |=> (free_count == $past(free_count) - COUNT_W'(1)))
  `GSSA_ASSERT(a_fail_gives_zero, clk, rst,
    (rsp_valid && rsp.status != ST_OK) |-> (rsp.alloc_top == '0))
  `GSSA_ASSERT(a_status_code, clk, rst,
    rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_EXHAUSTED ||
                   rsp.status == ST_MAP_FAIL))

endmodule
